### rtl/core/ssp_pkg.sv
// shared types, widths and codes of the stepper step pulse generator
`timescale 1ns / 1ps

package ssp_pkg;

    // field and state widths
    localparam int SPR_W    = 16;
    localparam int PW_W     = 8;
    localparam int RPM_W    = 13;
    localparam int DMODE_W  = 2;
    localparam int ANGLE_W  = 16;
    localparam int STATUS_W = 3;
    localparam int STEPS_W  = 24;
    localparam int PERIOD_W = 26;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // shared divider widths
    localparam int DIVD_W = 32;
    localparam int DIVS_W = 29;
    localparam int PROD_W = 32;

    // arithmetic constants
    localparam logic [DIVD_W-1:0] US_PER_MINUTE = 32'd60000000;
    localparam logic [DIVS_W-1:0] DEG_PER_REV   = 29'd360;

    // register reset values
    localparam logic [SPR_W-1:0]   SPR_RESET   = 16'd200;
    localparam logic [PW_W-1:0]    PW_RESET    = 8'd2;
    localparam logic [RPM_W-1:0]   RPM_RESET   = 13'd0;
    localparam logic [DMODE_W-1:0] DMODE_RESET = 2'd0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REV_STEPS      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH_US = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_RPM      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_MODE = 4'd3;

    // direction modes
    localparam logic [DMODE_W-1:0] DIR_CLOCKWISE = 2'd1;

    // request kinds
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_MOVE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_TICK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_FAST   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BUSY       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SPEED_ZERO = 3'd4;

    typedef struct packed {
        logic               mode;
        logic [ANGLE_W-1:0] angle;
    } in_t;

    typedef struct packed {
        logic                step_level;
        logic                dir_level;
        logic                busy_res;
        logic [STATUS_W-1:0] status;
    } out_t;

endpackage

### rtl/core/ssp_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ssp_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ssp_pkg::DIVD_W-1:0]   dividend,
    input  logic [ssp_pkg::DIVS_W-1:0]   divisor,
    output logic                         done,
    output logic [ssp_pkg::DIVD_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(ssp_pkg::DIVD_W);

    logic                        active_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [ssp_pkg::DIVS_W-1:0]  rem_reg;
    logic [ssp_pkg::DIVS_W-1:0]  dvs_reg;
    logic [ssp_pkg::DIVD_W-1:0]  quo_reg;

    logic [ssp_pkg::DIVS_W:0]    trial;
    logic [ssp_pkg::DIVS_W+1:0]  diff;
    logic                        fits;

    // trial subtract of the shifted remainder
    always_comb
    begin
        trial = {rem_reg, quo_reg[ssp_pkg::DIVD_W-1]};
        diff  = {1'b0, trial} - {2'b00, dvs_reg};
        fits  = ~diff[ssp_pkg::DIVS_W+1];
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ssp_pkg::DIVD_W - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (active_reg)
        begin
            rem_reg <= fits ? diff[ssp_pkg::DIVS_W-1:0] : trial[ssp_pkg::DIVS_W-1:0];
            quo_reg <= {quo_reg[ssp_pkg::DIVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/stepper_step_pulse_generator_unit.sv
// stepper step and direction pulse generator, top level
`timescale 1ns / 1ps

// Each request is either a one microsecond tick or a move. A tick, and a move
// refused because a move is still running, is answered in the cycle after it
// is taken, so ticks can follow back to back. Any other move holds in_ready
// low while it is worked out: one shared 16 by 16 multiplier forms speed times
// steps per revolution and then angle times steps per revolution, and one
// shared divider, one quotient bit per cycle, forms the step period and then
// the step count. A move with zero speed is refused after the first product,
// and one that is too fast after the period division. One result comes out
// per request through a registered output; a new request is taken in the
// cycle that the previous result is taken.

module stepper_step_pulse_generator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  ssp_pkg::in_t                     in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output ssp_pkg::out_t                    out_data
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MULP = 7'b0000010,
        S_CHKP = 7'b0000100,
        S_DIVP = 7'b0001000,
        S_MULS = 7'b0010000,
        S_STRS = 7'b0100000,
        S_DIVS = 7'b1000000
    } state_t;

    // configuration registers
    logic [ssp_pkg::SPR_W-1:0]   spr_reg;
    logic [ssp_pkg::PW_W-1:0]    pw_reg;
    logic [ssp_pkg::RPM_W-1:0]   rpm_reg;
    logic [ssp_pkg::DMODE_W-1:0] dmode_reg;

    // motion state
    logic [ssp_pkg::STEPS_W-1:0]  remaining_reg, remaining_next;
    logic [ssp_pkg::PERIOD_W-1:0] period_reg, period_next;
    logic [ssp_pkg::PERIOD_W-1:0] phase_reg, phase_next;
    logic                         dir_reg, dir_next;
    logic                         running_reg, running_next;

    // sequencer and datapath
    state_t                        state_reg, state_next;
    logic [ssp_pkg::ANGLE_W-1:0]   angle_reg;
    logic [ssp_pkg::PROD_W-1:0]    mul_reg;
    logic [ssp_pkg::SPR_W-1:0]     mul_a;
    logic [ssp_pkg::PROD_W-1:0]    mul_p;
    logic                          out_valid_reg, out_valid_next;
    ssp_pkg::out_t                 out_reg, out_next;

    logic                          accept;
    logic                          div_start;
    logic [ssp_pkg::DIVD_W-1:0]    div_dividend;
    logic [ssp_pkg::DIVS_W-1:0]    div_divisor;
    logic                          div_done;
    logic [ssp_pkg::DIVD_W-1:0]    div_quotient;
    logic [ssp_pkg::PERIOD_W-1:0]  phase_inc;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg   <= ssp_pkg::SPR_RESET;
            pw_reg    <= ssp_pkg::PW_RESET;
            rpm_reg   <= ssp_pkg::RPM_RESET;
            dmode_reg <= ssp_pkg::DMODE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ssp_pkg::REG_REV_STEPS:      spr_reg   <= cfg_data[ssp_pkg::SPR_W-1:0];
                ssp_pkg::REG_PULSE_WIDTH_US: pw_reg    <= cfg_data[ssp_pkg::PW_W-1:0];
                ssp_pkg::REG_SPEED_RPM:      rpm_reg   <= cfg_data[ssp_pkg::RPM_W-1:0];
                ssp_pkg::REG_DIRECTION_MODE: dmode_reg <= cfg_data[ssp_pkg::DMODE_W-1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier, operand chosen by the sequencer
    assign mul_a = (state_reg == S_MULP) ? {{(ssp_pkg::SPR_W-ssp_pkg::RPM_W){1'b0}}, rpm_reg}
                                         : angle_reg;
    assign mul_p = {{(ssp_pkg::PROD_W-ssp_pkg::SPR_W){1'b0}}, mul_a}
                 * {{(ssp_pkg::PROD_W-ssp_pkg::SPR_W){1'b0}}, spr_reg};

    always_ff @(posedge clk)
    begin
        if (accept)
            angle_reg <= in_data.angle;
        if (state_reg == S_MULP || state_reg == S_MULS)
            mul_reg <= mul_p;
    end

    // shared divider: period first, then step count
    assign div_start    = ((state_reg == S_CHKP) && (mul_reg != '0)) || (state_reg == S_STRS);
    assign div_dividend = (state_reg == S_CHKP) ? ssp_pkg::US_PER_MINUTE : mul_reg;
    assign div_divisor  = (state_reg == S_CHKP) ? mul_reg[ssp_pkg::DIVS_W-1:0]
                                                : ssp_pkg::DEG_PER_REV;

    ssp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign phase_inc = phase_reg + 1'b1;

    // sequencer, tick handling and result assembly
    always_comb
    begin
        state_next     = state_reg;
        remaining_next = remaining_reg;
        period_next    = period_reg;
        phase_next     = phase_reg;
        dir_next       = dir_reg;
        running_next   = running_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.mode == ssp_pkg::MODE_TICK)
                    begin
                        out_next.step_level = 1'b0;
                        if (running_reg)
                        begin
                            out_next.step_level =
                                (phase_reg < {{(ssp_pkg::PERIOD_W-ssp_pkg::PW_W){1'b0}}, pw_reg});
                            phase_next = phase_inc;
                            if (phase_inc >= period_reg)
                            begin
                                phase_next     = '0;
                                remaining_next = remaining_reg - 1'b1;
                                if (remaining_next == '0)
                                    running_next = 1'b0;
                            end
                        end
                        out_next.dir_level = dir_reg;
                        out_next.busy_res  = running_next;
                        out_next.status    = ssp_pkg::ST_TICK;
                        out_valid_next     = 1'b1;
                    end
                    else if (running_reg)
                    begin
                        out_next.step_level = 1'b0;
                        out_next.dir_level  = dir_reg;
                        out_next.busy_res   = 1'b1;
                        out_next.status     = ssp_pkg::ST_BUSY;
                        out_valid_next      = 1'b1;
                    end
                    else
                    begin
                        state_next = S_MULP;
                    end
                end
            end
            S_MULP:
            begin
                state_next = S_CHKP;
            end
            S_CHKP:
            begin
                if (mul_reg == '0)
                begin
                    out_next.step_level = 1'b0;
                    out_next.dir_level  = dir_reg;
                    out_next.busy_res   = 1'b0;
                    out_next.status     = ssp_pkg::ST_SPEED_ZERO;
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
                else
                begin
                    state_next = S_DIVP;
                end
            end
            S_DIVP:
            begin
                if (div_done)
                begin
                    if ({{(ssp_pkg::DIVD_W-ssp_pkg::PW_W){1'b0}}, pw_reg} >= div_quotient)
                    begin
                        out_next.step_level = 1'b0;
                        out_next.dir_level  = dir_reg;
                        out_next.busy_res   = 1'b0;
                        out_next.status     = ssp_pkg::ST_TOO_FAST;
                        out_valid_next      = 1'b1;
                        state_next          = S_IDLE;
                    end
                    else
                    begin
                        period_next = div_quotient[ssp_pkg::PERIOD_W-1:0];
                        state_next  = S_MULS;
                    end
                end
            end
            S_MULS:
            begin
                state_next = S_STRS;
            end
            S_STRS:
            begin
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                if (div_done)
                begin
                    remaining_next      = div_quotient[ssp_pkg::STEPS_W-1:0];
                    phase_next          = '0;
                    dir_next            = (dmode_reg == ssp_pkg::DIR_CLOCKWISE);
                    running_next        = (div_quotient[ssp_pkg::STEPS_W-1:0] != '0);
                    out_next.step_level = 1'b0;
                    out_next.dir_level  = dir_next;
                    out_next.busy_res   = running_next;
                    out_next.status     = ssp_pkg::ST_ACCEPTED;
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and motion state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            remaining_reg <= '0;
            period_reg    <= '0;
            phase_reg     <= '0;
            dir_reg       <= 1'b0;
            running_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            remaining_reg <= remaining_next;
            period_reg    <= period_next;
            phase_reg     <= phase_next;
            dir_reg       <= dir_next;
            running_reg   <= running_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef ASSERT_OFF
    // no result is pending while a move is being worked out
    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result pending during move computation");

    // a running move has a period above the pulse width, unless the configuration was just written
    a_period_set: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (period_reg > {{(ssp_pkg::PERIOD_W-ssp_pkg::PW_W){1'b0}}, pw_reg})
                        || $past(cfg_we))
        else $error("running with a period not above the pulse width");

    // a running move has steps left
    a_steps_left: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (remaining_reg != '0))
        else $error("running with no steps left");

    // divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVP || state_reg == S_DIVS))
        else $error("divider done outside a wait state");
`endif

endmodule
